FILE: hw/rtl/pcap_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width capture package
// Shared widths, codes and payload structures for the multichannel
// pulse-width capture block and its checker.
// ----------------------------------------------------------------------------
package pcap_pkg;

    // Default number of capture channels (legal range 1 to 8).
    localparam int CHANNEL_COUNT_DEF = 6;

    // Field widths fixed by the item format.
    localparam int CHANNEL_FIELD_W = 3;
    localparam int DATA_W          = 16;
    localparam int STEP_CNT_W      = $clog2(DATA_W);
    localparam int CFG_IDX_W       = 1;

    // Saturated scaled length.
    localparam logic [DATA_W-1:0] SAT_VALUE = {DATA_W{1'b1}};

    // Item actions.
    typedef enum logic [1:0] {
        ACT_EDGE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_READ  = 2'd3
    } pcap_action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_DISABLED = 2'd2,
        ST_NOINPUT  = 2'd3
    } pcap_status_t;

    // Per-channel edge phase.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } pcap_phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_MULT = 1'b0,
        REG_SCALE_DIV  = 1'b1
    } pcap_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2
    } pcap_state_t;

    // Input item.
    typedef struct packed {
        pcap_action_t               action;
        logic [CHANNEL_FIELD_W-1:0] channel;
        logic [DATA_W-1:0]          timestamp;
    } pcap_item_t;

    // Result item.
    typedef struct packed {
        pcap_status_t      status;
        logic [DATA_W-1:0] pulse_a;
        logic [DATA_W-1:0] pulse_b;
    } pcap_result_t;

endpackage

FILE: hw/rtl/multichannel_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// Multichannel pulse-width capture
// Per-channel edge capture of two alternating wave-part lengths, with a
// bit-serial scaled read-out (shift-add multiply, restoring divide).
// ----------------------------------------------------------------------------
// Usage:
// An item (action, channel, timestamp) is taken at a rising edge where start
// is high and busy is low. Every item produces exactly one result, shown on
// result for a single cycle with done high; the receiver must take it then.
// Edge, start and stop items, and reads that fail, give their result in the
// cycle after the transfer and never raise busy, so such items may be issued
// every cycle.
// A successful read loads both stored lengths into two serial lanes. Each
// lane multiplies by scale_multiplier one bit per cycle, then divides by
// scale_divisor one quotient bit per cycle. busy is high while the lanes
// work; the result appears as the divide ends and the next item can be
// taken in that same cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be issued while the block is idle.
// Reset stops every channel, sets all phases idle, zeroes the stored lengths
// and sets both scale registers to one.
// ----------------------------------------------------------------------------
module multichannel_pulse_width_capture
    import pcap_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pcap_item_t            item,
    output logic                  done,
    output pcap_result_t          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int LANES    = 2;
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DATA_W - 1);

    // Configuration registers.
    logic [DATA_W-1:0] mult_reg;
    logic [DATA_W-1:0] div_reg;

    // Per-channel state.
    logic [CHANNEL_COUNT-1:0] active_reg, active_next;
    pcap_phase_t              phase_reg  [CHANNEL_COUNT];
    pcap_phase_t              phase_next [CHANNEL_COUNT];
    logic [DATA_W-1:0]        len_a_reg  [CHANNEL_COUNT];
    logic [DATA_W-1:0]        len_a_next [CHANNEL_COUNT];
    logic [DATA_W-1:0]        len_b_reg  [CHANNEL_COUNT];
    logic [DATA_W-1:0]        len_b_next [CHANNEL_COUNT];
    logic [DATA_W-1:0]        stamp_mem  [CHANNEL_COUNT];
    logic                     stamp_we;

    // Sequencer.
    pcap_state_t           state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;

    // Serial arithmetic lanes: lane 0 scales the first length, lane 1 the second.
    logic [DATA_W-1:0] mcand_reg [LANES];
    logic [DATA_W-1:0] mcand_next[LANES];
    logic [DATA_W-1:0] hi_reg    [LANES];
    logic [DATA_W-1:0] hi_next   [LANES];
    logic [DATA_W-1:0] lo_reg    [LANES];
    logic [DATA_W-1:0] lo_next   [LANES];
    logic              sat_reg   [LANES];
    logic              sat_next  [LANES];
    logic              zero_reg  [LANES];
    logic              zero_next [LANES];
    logic [DATA_W:0]   lane_sum  [LANES];
    logic [DATA_W:0]   lane_rsh  [LANES];
    logic [DATA_W:0]   lane_diff [LANES];
    logic              lane_ge   [LANES];
    logic [DATA_W-1:0] lane_out  [LANES];

    // Result register.
    logic         done_reg, done_next;
    pcap_result_t result_reg, result_next;

    // Item decode.
    logic                ch_ok;
    logic [CH_IDX_W-1:0] idx;
    logic [DATA_W-1:0]   edge_len;
    pcap_status_t        status_w;
    logic                go_read;

    assign ch_ok    = {1'b0, item.channel} < (CHANNEL_FIELD_W + 1)'(CHANNEL_COUNT);
    assign idx      = item.channel[CH_IDX_W-1:0];
    assign edge_len = item.timestamp - stamp_mem[idx];

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= DATA_W'(1);
            div_reg  <= DATA_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (pcap_reg_t'(cfg_index))
                REG_SCALE_MULT: mult_reg <= cfg_data;
                REG_SCALE_DIV:  div_reg  <= cfg_data;
            endcase
        end
    end

    // Control and channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            active_reg <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                phase_reg[c] <= PH_IDLE;
                len_a_reg[c] <= '0;
                len_b_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            phase_reg  <= phase_next;
            len_a_reg  <= len_a_next;
            len_b_reg  <= len_b_next;
        end
    end

    // Start stamps are always written before they are used.
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[idx] <= item.timestamp;
        end
    end

    // Lane datapath registers.
    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        sat_reg   <= sat_next;
        zero_reg  <= zero_next;
    end

    // One multiply step (conditional add, shift right) and one divide step
    // (shift left, compare, subtract) for each lane.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_sum[l]  = {1'b0, hi_reg[l]} + (lo_reg[l][0] ? {1'b0, mcand_reg[l]} : '0);
            lane_rsh[l]  = {hi_reg[l], lo_reg[l][DATA_W-1]};
            lane_diff[l] = lane_rsh[l] - {1'b0, div_reg};
            lane_ge[l]   = (lane_rsh[l] >= {1'b0, div_reg});
        end
    end

    // Next state, channel updates and result.
    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        len_a_next  = len_a_reg;
        len_b_next  = len_b_reg;
        stamp_we    = 1'b0;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        sat_next    = sat_reg;
        zero_next   = zero_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        status_w    = ST_OK;
        go_read     = 1'b0;
        lane_out[0] = '0;
        lane_out[1] = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!ch_ok)
                    begin
                        status_w = ST_INVALID;
                    end
                    else
                    begin
                        unique case (item.action)
                            ACT_EDGE:
                            begin
                                if (active_reg[idx])
                                begin
                                    unique case (phase_reg[idx])
                                        PH_IDLE:
                                        begin
                                            stamp_we        = 1'b1;
                                            phase_next[idx] = PH_FIRST;
                                        end
                                        PH_FIRST:
                                        begin
                                            len_a_next[idx] = edge_len;
                                            stamp_we        = 1'b1;
                                            phase_next[idx] = PH_SECOND;
                                        end
                                        PH_SECOND:
                                        begin
                                            len_b_next[idx] = edge_len;
                                            stamp_we        = 1'b1;
                                            phase_next[idx] = PH_FIRST;
                                        end
                                        default:
                                        begin
                                            stamp_we = 1'b0;
                                        end
                                    endcase
                                end
                                else
                                begin
                                    status_w = ST_DISABLED;
                                end
                            end
                            ACT_START:
                            begin
                                active_next[idx] = 1'b1;
                            end
                            ACT_STOP:
                            begin
                                active_next[idx] = 1'b0;
                                phase_next[idx]  = PH_IDLE;
                                len_a_next[idx]  = '0;
                                len_b_next[idx]  = '0;
                            end
                            ACT_READ:
                            begin
                                if (!active_reg[idx])
                                begin
                                    status_w = ST_DISABLED;
                                end
                                else if (phase_reg[idx] == PH_IDLE)
                                begin
                                    status_w = ST_NOINPUT;
                                end
                                else if (len_a_reg[idx] == '0 && len_b_reg[idx] == '0)
                                begin
                                    status_w = ST_NOINPUT;
                                end
                                else
                                begin
                                    go_read         = 1'b1;
                                    len_a_next[idx] = '0;
                                    len_b_next[idx] = '0;
                                end
                            end
                        endcase
                    end

                    if (go_read)
                    begin
                        // Load both lanes; the multiplier bits enter the low half.
                        mcand_next[0] = len_a_reg[idx];
                        mcand_next[1] = len_b_reg[idx];
                        for (int l = 0; l < LANES; l++)
                        begin
                            hi_next[l] = '0;
                            lo_next[l] = mult_reg;
                        end
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        done_next           = 1'b1;
                        result_next.status  = status_w;
                        result_next.pulse_a = '0;
                        result_next.pulse_b = '0;
                    end
                end
            end

            S_MUL:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    hi_next[l] = lane_sum[l][DATA_W:1];
                    lo_next[l] = {lane_sum[l][0], lo_reg[l][DATA_W-1:1]};
                end
                if (cnt_reg == LAST_STEP)
                begin
                    // The quotient overflows 16 bits exactly when the upper
                    // product half reaches the divisor; a zero divisor
                    // always lands here.
                    for (int l = 0; l < LANES; l++)
                    begin
                        sat_next[l]  = (hi_next[l] >= div_reg);
                        zero_next[l] = (hi_next[l] == '0) && (lo_next[l] == '0);
                    end
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_CNT_W'(1);
                end
            end

            S_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    hi_next[l] = lane_ge[l] ? lane_diff[l][DATA_W-1:0]
                                            : lane_rsh[l][DATA_W-1:0];
                    lo_next[l] = {lo_reg[l][DATA_W-2:0], lane_ge[l]};
                    if (sat_reg[l])
                    begin
                        lane_out[l] = zero_reg[l] ? '0 : SAT_VALUE;
                    end
                    else
                    begin
                        lane_out[l] = lo_next[l];
                    end
                end
                if (cnt_reg == LAST_STEP)
                begin
                    done_next           = 1'b1;
                    result_next.status  = ST_OK;
                    result_next.pulse_a = lane_out[0];
                    result_next.pulse_b = lane_out[1];
                    cnt_next            = '0;
                    state_next          = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pcap_checker.sv
// ----------------------------------------------------------------------------
// Pulse-width capture checker
// Port-level properties of the capture block, bound to its top level.
// ----------------------------------------------------------------------------
module pcap_assertions
    import pcap_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input pcap_item_t   item,
    input logic         done,
    input pcap_result_t result
);

    logic transfer;
    logic bad_channel;

    assign transfer    = start && !busy;
    assign bad_channel = {1'b0, item.channel} >= (CHANNEL_FIELD_W + 1)'(CHANNEL_COUNT);

    // Any item other than a read is answered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        transfer && item.action != ACT_READ |=> done && !busy)
    else $error("non-read transfer not answered in the next cycle");

    // An item on a channel beyond the channel count reports an invalid channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        transfer && bad_channel |=> done && result.status == ST_INVALID)
    else $error("invalid channel not reported");

    // Only a successful read carries nonzero lengths.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.pulse_a == '0 && result.pulse_b == '0)
    else $error("failed result carries nonzero lengths");

    // The block only goes busy after accepting a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(transfer && item.action == ACT_READ))
    else $error("busy raised without a read transfer");

endmodule

bind multichannel_pulse_width_capture pcap_assertions #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
) u_pcap_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

FILE: tb/sv/pcap_checker.sv
// ----------------------------------------------------------------------------
// Pulse-width capture checker
// Watches the item, result and register ports of the capture block, predicts
// one result per item transfer and compares each result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pcap_checker
    import pcap_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  pcap_item_t           item,
    input  logic                 done,
    input  pcap_result_t         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the block's registers and per-channel capture state.
    logic [DATA_W-1:0]        scale_mult;
    logic [DATA_W-1:0]        scale_div;
    logic [CHANNEL_COUNT-1:0] enabled;
    pcap_phase_t              phase       [CHANNEL_COUNT];
    logic [DATA_W-1:0]        last_stamp  [CHANNEL_COUNT];
    logic [DATA_W-1:0]        first_len   [CHANNEL_COUNT];
    logic [DATA_W-1:0]        second_len  [CHANNEL_COUNT];

    // Results still owed by the block, oldest first.
    pcap_result_t expected_results [$];

    // Scales a stored length by multiplier over divisor, saturating at 16 bits.
    function automatic logic [DATA_W-1:0] scaled_length(logic [DATA_W-1:0] len);
        logic [2*DATA_W-1:0] product;
        logic [2*DATA_W-1:0] quotient;
        product = {{DATA_W{1'b0}}, len} * {{DATA_W{1'b0}}, scale_mult};
        if (scale_div == '0)
        begin
            return (product != '0) ? SAT_VALUE : '0;
        end
        quotient = product / {{DATA_W{1'b0}}, scale_div};
        return (quotient > {{DATA_W{1'b0}}, SAT_VALUE}) ? SAT_VALUE : quotient[DATA_W-1:0];
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic pcap_result_t capture_outcome(pcap_item_t it);
        pcap_result_t      res;
        int                ch;
        logic [DATA_W-1:0] part_len;
        res = '{status: ST_OK, pulse_a: '0, pulse_b: '0};
        ch  = int'(it.channel);
        if (ch >= CHANNEL_COUNT)
        begin
            res.status = ST_INVALID;
            return res;
        end
        case (it.action)
            ACT_EDGE:
            begin
                if (!enabled[ch])
                begin
                    res.status = ST_DISABLED;
                end
                else
                begin
                    // The part that just ended is measured modulo 2^16.
                    part_len = it.timestamp - last_stamp[ch];
                    case (phase[ch])
                        PH_IDLE:
                        begin
                            last_stamp[ch] = it.timestamp;
                            phase[ch]      = PH_FIRST;
                        end
                        PH_FIRST:
                        begin
                            first_len[ch]  = part_len;
                            last_stamp[ch] = it.timestamp;
                            phase[ch]      = PH_SECOND;
                        end
                        PH_SECOND:
                        begin
                            second_len[ch] = part_len;
                            last_stamp[ch] = it.timestamp;
                            phase[ch]      = PH_FIRST;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ACT_START:
            begin
                enabled[ch] = 1'b1;
            end
            ACT_STOP:
            begin
                enabled[ch]    = 1'b0;
                phase[ch]      = PH_IDLE;
                first_len[ch]  = '0;
                second_len[ch] = '0;
            end
            default:
            begin
                if (!enabled[ch])
                begin
                    res.status = ST_DISABLED;
                end
                else if (phase[ch] == PH_IDLE)
                begin
                    res.status = ST_NOINPUT;
                end
                else if (first_len[ch] == '0 && second_len[ch] == '0)
                begin
                    res.status = ST_NOINPUT;
                end
                else
                begin
                    res.pulse_a    = scaled_length(first_len[ch]);
                    res.pulse_b    = scaled_length(second_len[ch]);
                    first_len[ch]  = '0;
                    second_len[ch] = '0;
                end
            end
        endcase
        return res;
    endfunction

    // Reports a single field that differs from its prediction.
    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Result transfers are checked first, then register writes and item
    // transfers update the shadow state.
    always @(posedge clk or negedge rst_n)
    begin : watch
        pcap_result_t want;
        if (!rst_n)
        begin
            scale_mult = 16'd1;
            scale_div  = 16'd1;
            enabled    = '0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                phase[c]      = PH_IDLE;
                last_stamp[c] = '0;
                first_len[c]  = '0;
                second_len[c] = '0;
            end
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no result outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, result.status);
                    compare_field("pulse_a", want.pulse_a, result.pulse_a);
                    compare_field("pulse_b", want.pulse_b, result.pulse_b);
                end
            end
            if (cfg_we)
            begin
                case (pcap_reg_t'(cfg_index))
                    REG_SCALE_MULT: scale_mult = cfg_data;
                    REG_SCALE_DIV:  scale_div  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (start && !busy)
            begin
                expected_results.push_back(capture_outcome(item));
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Pulse-width capture testbench
// Drives directed and random capture, start, stop and read items into the
// block under several scale settings, with random gaps between transfers,
// and takes its verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb;

    import pcap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS       = CHANNEL_COUNT_DEF;
    localparam int SCALE_SETTINGS = 7;
    localparam int ITEMS_PER_SET  = 140;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 4000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    pcap_item_t           item      = '0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 busy;
    logic                 done;
    pcap_result_t         result;
    int                   fail_count;
    int                   pending;

    // Whether random gaps are put between item transfers.
    bit                   gaps_on = 1'b0;
    // Last timestamp sent on each channel, so that edges form real pulses.
    logic [DATA_W-1:0]    last_ts [CHANNELS];
    int                   stall_cycles = 0;

    always #10 clk = ~clk;

    multichannel_pulse_width_capture #(
        .CHANNEL_COUNT (CHANNELS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcap_checker #(
        .CHANNEL_COUNT (CHANNELS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offers one item and holds it until the block takes it, then maybe idles.
    task automatic send(pcap_action_t act, logic [2:0] ch, logic [DATA_W-1:0] ts);
        item  <= '{action: act, channel: ch, timestamp: ts};
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every outstanding result is in.
    task automatic drain(int settle);
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Writes both scale registers on consecutive cycles; the block is idle.
    task automatic set_scale(logic [DATA_W-1:0] mult, logic [DATA_W-1:0] div);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCALE_MULT;
        cfg_data  <= mult;
        @(posedge clk);
        cfg_index <= REG_SCALE_DIV;
        cfg_data  <= div;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly edges that follow on from the channel's last timestamp, with
    // reads, starts and stops mixed in and a little invalid-channel noise.
    task automatic random_items(int count, bit allow_gaps);
        int                pick;
        logic [2:0]        ch;
        logic [DATA_W-1:0] step;
        for (int n = 0; n < count; n++)
        begin
            if (n % 48 == 0)
            begin
                gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            ch   = 3'($urandom_range(0, CHANNELS - 1));
            if (pick < 6)
            begin
                send(pcap_action_t'($urandom_range(0, 3)),
                     3'($urandom_range(CHANNELS, 7)), DATA_W'($urandom));
            end
            else if (pick < 16)
            begin
                send(ACT_START, ch, DATA_W'($urandom));
            end
            else if (pick < 20)
            begin
                send(ACT_STOP, ch, DATA_W'($urandom));
            end
            else if (pick < 42)
            begin
                send(ACT_READ, ch, DATA_W'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       step = DATA_W'($urandom_range(0, 15));
                    1:       step = DATA_W'($urandom_range(16'hFFF0, 16'hFFFF));
                    2:       step = DATA_W'($urandom_range(16, 1023));
                    default: step = DATA_W'($urandom);
                endcase
                last_ts[ch] = last_ts[ch] + step;
                send(ACT_EDGE, ch, last_ts[ch]);
            end
        end
    endtask

    // A run with no transfer in either direction for too long has hung.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            last_ts[c] = DATA_W'($urandom);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_scale(16'd1, 16'd1);

        // Directed: invalid and stopped channels, idle and empty reads,
        // wrapping and zero-length parts, full-range part, restart and stop.
        send(ACT_EDGE,  3'd7, 16'h1234);
        send(ACT_START, 3'd6, 16'h0000);
        send(ACT_STOP,  3'd7, 16'hFFFF);
        send(ACT_READ,  3'd6, 16'h0000);
        send(ACT_EDGE,  3'd0, 16'h0100);
        send(ACT_READ,  3'd0, 16'h0000);
        send(ACT_START, 3'd0, 16'h0000);
        send(ACT_READ,  3'd0, 16'h0000);
        send(ACT_EDGE,  3'd0, 16'hFFF0);
        send(ACT_READ,  3'd0, 16'h0000);
        send(ACT_EDGE,  3'd0, 16'h0010);
        send(ACT_EDGE,  3'd0, 16'hFFFF);
        send(ACT_READ,  3'd0, 16'h0000);
        send(ACT_READ,  3'd0, 16'h0000);
        send(ACT_START, 3'd0, 16'h0000);
        send(ACT_EDGE,  3'd0, 16'hFFFF);
        send(ACT_START, 3'd5, 16'h0000);
        send(ACT_EDGE,  3'd5, 16'h0000);
        send(ACT_EDGE,  3'd5, 16'hFFFF);
        send(ACT_READ,  3'd5, 16'hFFFF);
        send(ACT_STOP,  3'd5, 16'h0000);
        send(ACT_READ,  3'd5, 16'h0000);
        send(ACT_EDGE,  3'd5, 16'h5555);
        send(ACT_STOP,  3'd0, 16'hAAAA);

        // Random items under a sequence of scale settings, extremes first.
        for (int s = 0; s < SCALE_SETTINGS; s++)
        begin
            drain(2);
            case (s)
                0:       set_scale(16'hFFFF, 16'd1);
                1:       set_scale(16'd1, 16'hFFFF);
                2:       set_scale(16'hFFFF, 16'hFFFF);
                3:       set_scale(DATA_W'($urandom_range(1, 65535)),
                                   DATA_W'($urandom_range(1, 65535)));
                4:       set_scale(DATA_W'($urandom_range(1, 65535)),
                                   DATA_W'($urandom_range(1, 16)));
                5:       set_scale(DATA_W'($urandom_range(1, 64)),
                                   DATA_W'($urandom_range(1, 65535)));
                default: set_scale(16'd1, 16'd1);
            endcase
            random_items(ITEMS_PER_SET, s != SCALE_SETTINGS - 1);
        end

        drain(SETTLE_CYCLES);
        if (fail_count == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
